// ----- rtl/ecsc_pkg.sv -----
// ----------------------------------------------------------------------------
// ecsc_pkg
// Shared types and constants for the envelope compressor with soft clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package ecsc_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int COEF_W      = 16;
	localparam int MAX_BLOCK   = 8192;
	localparam int COUNT_W     = 14;
	localparam int SUM_W       = 37;
	localparam int MUL_W       = 32;
	localparam int DIV_NUM_W   = 54;
	localparam int DIV_DEN_W   = 25;
	localparam int SQRT_RAD_W  = 62;
	localparam int SQRT_ROOT_W = 31;

	localparam logic [30:0] HALF_PI_Q30   = 31'd1686629362;
	localparam logic [30:0] ONE_Q30       = 31'd1073741824;
	localparam logic [16:0] LOUD_GAIN_Q16 = 17'd92406;

	localparam logic [1:0] REG_SMOOTH_COEF  = 2'd0;
	localparam logic [1:0] REG_MASTER_GAIN  = 2'd1;
	localparam logic [1:0] REG_ENV_FLOOR    = 2'd2;
	localparam logic [1:0] REG_OUTPUT_SCALE = 2'd3;

	localparam logic [15:0] SMOOTH_COEF_RST  = 16'd41;
	localparam logic [15:0] MASTER_GAIN_RST  = 16'd16384;
	localparam logic [15:0] ENV_FLOOR_RST    = 16'd6554;
	localparam logic [15:0] OUTPUT_SCALE_RST = 16'd62259;

	typedef struct packed {
		logic signed [23:0] sample_in;
		logic               channel;
		logic               block_last;
	} in_t;

	typedef struct packed {
		logic signed [23:0] sample_out;
		logic [15:0]        loudness;
		logic               loudness_valid;
	} out_t;

	// Horner steps of the sine divide by 110, 72, 42, 20 and 6. The even
	// factor is shifted out first, then floor(n / d) = (n * rcp) >> shr,
	// exact for any numerator below 2^32.
	function automatic logic [1:0] taylor_pre(input logic [2:0] idx);
		logic [1:0] p;
		unique case (idx)
			3'd0:    p = 2'd1;
			3'd1:    p = 2'd3;
			3'd2:    p = 2'd1;
			3'd3:    p = 2'd2;
			default: p = 2'd1;
		endcase
		return p;
	endfunction

	function automatic logic [31:0] taylor_rcp(input logic [2:0] idx);
		logic [31:0] r;
		unique case (idx)
			3'd0:    r = 32'd2498890064;
			3'd1:    r = 32'd3817748708;
			3'd2:    r = 32'd3272356036;
			3'd3:    r = 32'd3435973837;
			default: r = 32'd2863311531;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] taylor_shr(input logic [2:0] idx);
		logic [5:0] s;
		unique case (idx)
			3'd0:    s = 6'd37;
			3'd1:    s = 6'd35;
			3'd2:    s = 6'd36;
			3'd3:    s = 6'd34;
			default: s = 6'd33;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ecsc_mul.sv -----
// ----------------------------------------------------------------------------
// ecsc_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsc_mul (
	input  wire logic                            clk,
	input  wire logic [ecsc_pkg::MUL_W-1:0]      a,
	input  wire logic [ecsc_pkg::MUL_W-1:0]      b,
	output logic      [2*ecsc_pkg::MUL_W-1:0]    prod
);

	logic [2*ecsc_pkg::MUL_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

// ----- rtl/ecsc_div.sv -----
// ----------------------------------------------------------------------------
// ecsc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsc_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [ecsc_pkg::DIV_NUM_W-1:0]    num,
	input  wire logic [ecsc_pkg::DIV_DEN_W-1:0]    den,
	output logic                                   done,
	output logic      [ecsc_pkg::DIV_NUM_W-1:0]    quo
);

	logic                              busy_q;
	logic                              done_q;
	logic [5:0]                        cnt_q;
	logic [ecsc_pkg::DIV_DEN_W-1:0]    rem_q;
	logic [ecsc_pkg::DIV_DEN_W-1:0]    den_q;
	logic [ecsc_pkg::DIV_NUM_W-1:0]    quo_q;
	logic [ecsc_pkg::DIV_DEN_W:0]      rem_sh;
	logic [ecsc_pkg::DIV_DEN_W:0]      rem_sub;
	logic                              ge;

	assign rem_sh  = {rem_q, quo_q[ecsc_pkg::DIV_NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(ecsc_pkg::DIV_NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[ecsc_pkg::DIV_DEN_W-1:0] : rem_sh[ecsc_pkg::DIV_DEN_W-1:0];
			quo_q <= {quo_q[ecsc_pkg::DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// ----- rtl/ecsc_sqrt.sv -----
// ----------------------------------------------------------------------------
// ecsc_sqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsc_sqrt (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [ecsc_pkg::SQRT_RAD_W-1:0]     rad,
	output logic                                     done,
	output logic      [ecsc_pkg::SQRT_ROOT_W-1:0]    root
);

	logic                                busy_q;
	logic                                done_q;
	logic [4:0]                          cnt_q;
	logic [32:0]                         rem_q;
	logic [ecsc_pkg::SQRT_ROOT_W-1:0]    root_q;
	logic [ecsc_pkg::SQRT_RAD_W-1:0]     val_q;
	logic [32:0]                         rem_sh;
	logic [32:0]                         trial;
	logic                                ge;

	assign rem_sh = {rem_q[30:0], val_q[ecsc_pkg::SQRT_RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(ecsc_pkg::SQRT_ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			val_q  <= rad;
		end else if (busy_q) begin
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ecsc_pkg::SQRT_ROOT_W-2:0], ge};
			val_q  <= {val_q[ecsc_pkg::SQRT_RAD_W-3:0], 2'b00};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ----- rtl/envelope_compressor_soft_clip_core.sv -----
// ----------------------------------------------------------------------------
// envelope_compressor_soft_clip_core
// Per-channel envelope compressor with sine soft clipper and block loudness.
//
// Input channel: sample (sample_in, channel, block_last) moves on a
// sample_valid/sample_ready transfer. Output channel: result (sample_out,
// loudness, loudness_valid) on result_valid/result_ready. One result per
// sample. Registers are to be written through the APB port only while idle;
// the core does not enforce this. A sample is worked by a sequencer around
// one shared 32x32 multiplier, a 54-bit bit-serial divider and a 31-bit
// bit-serial square root; the sine's constant divisions are reciprocal
// products on the multiplier. result_valid rises after the angle division
// and the sine; a sample closing a block adds the mean division and the
// square root. sample_ready is high only while the sequencer is idle, so a
// new sample is taken only once the sequencer is through with the last one.
// The next sample is taken while a finished result still sits in the output
// register. If the receiver stalls, the next result waits in the sequencer
// until the output register frees. Reset clears envelopes, the block sum
// and count, and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module envelope_compressor_soft_clip_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            sample_valid,
	output logic                 sample_ready,
	input  wire ecsc_pkg::in_t   sample,
	output logic                 result_valid,
	input  wire logic            result_ready,
	output ecsc_pkg::out_t       result,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [3:0]      paddr,
	input  wire logic [31:0]     pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ENV1  = 4'd1;
	localparam logic [3:0] ST_ENV2  = 4'd2;
	localparam logic [3:0] ST_ENV3  = 4'd3;
	localparam logic [3:0] ST_ANG   = 4'd4;
	localparam logic [3:0] ST_ANGW  = 4'd5;
	localparam logic [3:0] ST_SQ    = 4'd6;
	localparam logic [3:0] ST_TMUL  = 4'd7;
	localparam logic [3:0] ST_TREC  = 4'd8;
	localparam logic [3:0] ST_SIN   = 4'd9;
	localparam logic [3:0] ST_SCALE = 4'd10;
	localparam logic [3:0] ST_MEANW = 4'd11;
	localparam logic [3:0] ST_ROOTW = 4'd12;
	localparam logic [3:0] ST_LOUD  = 4'd13;
	localparam logic [3:0] ST_OUT   = 4'd14;

	logic [3:0]  state_q;

	logic [15:0] smooth_coef_q;
	logic [15:0] master_gain_q;
	logic [15:0] env_floor_q;
	logic [15:0] output_scale_q;

	logic [23:0] envelope_q [2];
	logic [ecsc_pkg::SUM_W-1:0]   sum_q;
	logic [ecsc_pkg::COUNT_W-1:0] count_q;

	logic [23:0] mag_q;
	logic        neg_q;
	logic        ch_q;
	logic        last_q;
	logic [39:0] acc_q;
	logic [23:0] env_q;
	logic [30:0] ang_q;
	logic [31:0] x2_q;
	logic [2:0]  k_q;
	logic [23:0] y_q;
	logic [15:0] loud_q;

	logic        out_valid_q;
	ecsc_pkg::out_t out_q;

	// shared units
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic        div_start;
	logic [ecsc_pkg::DIV_NUM_W-1:0] div_num;
	logic [ecsc_pkg::DIV_DEN_W-1:0] div_den;
	logic        div_done;
	logic [ecsc_pkg::DIV_NUM_W-1:0] quo;
	logic        sqrt_start;
	logic        sqrt_done;
	logic [ecsc_pkg::SQRT_ROOT_W-1:0] root;

	logic [23:0] in_mag;
	logic [40:0] env_sum;
	logic [24:0] den;
	logic [24:0] y_round;
	logic [47:0] loud_full;
	logic [30:0] sin_full;
	logic [30:0] t_quo;
	logic [30:0] t_next;
	logic [ecsc_pkg::COUNT_W-1:0] cnt_div;
	logic        cfg_wr;

	ecsc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	ecsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	ecsc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    ({quo[23:0], 38'd0} >> 1),
		.done   (sqrt_done),
		.root   (root)
	);

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		unique case (paddr[3:2])
			ecsc_pkg::REG_SMOOTH_COEF:  prdata = {16'd0, smooth_coef_q};
			ecsc_pkg::REG_MASTER_GAIN:  prdata = {16'd0, master_gain_q};
			ecsc_pkg::REG_ENV_FLOOR:    prdata = {16'd0, env_floor_q};
			ecsc_pkg::REG_OUTPUT_SCALE: prdata = {16'd0, output_scale_q};
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_coef_q  <= ecsc_pkg::SMOOTH_COEF_RST;
			master_gain_q  <= ecsc_pkg::MASTER_GAIN_RST;
			env_floor_q    <= ecsc_pkg::ENV_FLOOR_RST;
			output_scale_q <= ecsc_pkg::OUTPUT_SCALE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				ecsc_pkg::REG_SMOOTH_COEF:  smooth_coef_q  <= pwdata[15:0];
				ecsc_pkg::REG_MASTER_GAIN:  master_gain_q  <= pwdata[15:0];
				ecsc_pkg::REG_ENV_FLOOR:    env_floor_q    <= pwdata[15:0];
				ecsc_pkg::REG_OUTPUT_SCALE: output_scale_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// datapath helpers
	assign in_mag   = sample.sample_in[23] ? (24'd0 - sample.sample_in) : sample.sample_in;
	assign env_sum  = {1'b0, acc_q} + {1'b0, prod[39:0]} + 41'd32768;
	assign den      = {1'b0, env_q} + {2'b0, env_floor_q, 7'd0};
	assign y_round  = 25'((prod[47:0] + 48'd4194304) >> 23);
	assign loud_full = prod[47:0] + 48'd1073741824;
	assign sin_full = (prod[61:30] > {1'b0, ecsc_pkg::ONE_Q30}) ? ecsc_pkg::ONE_Q30
	                                                           : prod[60:30];
	assign t_quo    = 31'(prod >> ecsc_pkg::taylor_shr(k_q));
	assign t_next   = ecsc_pkg::ONE_Q30 - t_quo;
	assign cnt_div  = (count_q == '0) ? ecsc_pkg::COUNT_W'(1) : count_q;

	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		mul_a      = '0;
		mul_b      = '0;
		div_start  = 1'b0;
		div_num    = '0;
		div_den    = '0;
		sqrt_start = 1'b0;
		unique case (state_q)
			ST_ENV1: begin
				mul_a = {8'd0, envelope_q[ch_q]};
				mul_b = 32'(17'h10000 - {1'b0, smooth_coef_q});
			end
			ST_ENV2: begin
				mul_a = {8'd0, mag_q};
				mul_b = {16'd0, smooth_coef_q};
			end
			ST_ENV3: begin
				mul_a = {8'd0, mag_q};
				mul_b = {16'd0, master_gain_q};
			end
			ST_ANG: begin
				div_start = 1'b1;
				div_num   = {prod[38:0], 15'd0};
				div_den   = (den == '0) ? 25'd1 : den;
			end
			ST_ANGW: begin
				mul_a = {1'b0, ang_q};
				mul_b = {1'b0, ang_q};
				if (div_done) begin
					mul_a = (quo > 54'(ecsc_pkg::HALF_PI_Q30)) ?
					        {1'b0, ecsc_pkg::HALF_PI_Q30} : {1'b0, quo[30:0]};
					mul_b = mul_a;
				end
			end
			// first Horner step: x2 * 1.0 is x2 itself
			ST_SQ: begin
				mul_a = prod[61:30] >> ecsc_pkg::taylor_pre(3'd0);
				mul_b = ecsc_pkg::taylor_rcp(3'd0);
			end
			ST_TMUL: begin
				mul_a = prod[61:30] >> ecsc_pkg::taylor_pre(k_q);
				mul_b = ecsc_pkg::taylor_rcp(k_q);
			end
			ST_TREC: begin
				mul_a = (k_q == 3'd4) ? {1'b0, ang_q} : x2_q;
				mul_b = {1'b0, t_next};
			end
			ST_SIN: begin
				mul_a = {1'b0, sin_full};
				mul_b = {16'd0, output_scale_q};
			end
			ST_SCALE: begin
				if (last_q) begin
					div_start = 1'b1;
					div_num   = 54'(sum_q);
					div_den   = 25'(cnt_div);
				end
			end
			ST_MEANW: begin
				sqrt_start = div_done;
			end
			ST_ROOTW: begin
				mul_a = {1'b0, root};
				mul_b = {15'd0, ecsc_pkg::LOUD_GAIN_Q16};
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			envelope_q[0] <= '0;
			envelope_q[1] <= '0;
			sum_q         <= '0;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || result_ready)) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						state_q <= ST_ENV1;
					end
				end
				ST_ENV1:  state_q <= ST_ENV2;
				ST_ENV2:  state_q <= ST_ENV3;
				ST_ENV3: begin
					envelope_q[ch_q] <= env_sum[39:16];
					if (count_q < ecsc_pkg::COUNT_W'(ecsc_pkg::MAX_BLOCK)) begin
						sum_q   <= sum_q + ecsc_pkg::SUM_W'(env_sum[39:16]);
						count_q <= count_q + ecsc_pkg::COUNT_W'(1);
					end
					state_q <= ST_ANG;
				end
				ST_ANG:   state_q <= ST_ANGW;
				ST_ANGW: begin
					if (div_done) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ:    state_q <= ST_TREC;
				ST_TMUL:  state_q <= ST_TREC;
				ST_TREC:  state_q <= (k_q == 3'd4) ? ST_SIN : ST_TMUL;
				ST_SIN:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= last_q ? ST_MEANW : ST_OUT;
				ST_MEANW: begin
					if (div_done) begin
						state_q <= ST_ROOTW;
					end
				end
				ST_ROOTW: begin
					if (sqrt_done) begin
						state_q <= ST_LOUD;
					end
				end
				ST_LOUD: begin
					sum_q   <= '0;
					count_q <= '0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mag_q  <= in_mag;
				neg_q  <= sample.sample_in[23];
				ch_q   <= sample.channel;
				last_q <= sample.block_last;
				loud_q <= '0;
			end
			ST_ENV2:  acc_q <= prod[39:0];
			ST_ENV3:  env_q <= env_sum[39:16];
			ST_ANGW: begin
				if (div_done) begin
					ang_q <= (quo > 54'(ecsc_pkg::HALF_PI_Q30)) ?
					         ecsc_pkg::HALF_PI_Q30 : quo[30:0];
				end
			end
			ST_SQ: begin
				x2_q <= prod[61:30];
				k_q  <= '0;
			end
			ST_TREC:  k_q <= k_q + 3'd1;
			ST_SCALE: begin
				y_q <= (y_round > 25'd8388607) ? 24'd8388607 : y_round[23:0];
			end
			ST_LOUD: begin
				loud_q <= (loud_full[47:31] > 17'd65535) ? 16'hFFFF : loud_full[46:31];
			end
			ST_OUT: begin
				if (!out_valid_q || result_ready) begin
					out_q.sample_out     <= neg_q ? (24'd0 - y_q) : y_q;
					out_q.loudness       <= loud_q;
					out_q.loudness_valid <= last_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- sim/ecsc_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecsc_result_checker
// Watches the sample, result and register ports of the compressor core.
// For every sample transfer it computes the expected output sample and
// block loudness in fixed point, keeping its own envelopes, block sum and
// register copies. Each result transfer is compared field by field with
// the oldest expectation. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsc_result_checker
	import ecsc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  sample_valid,
	input  wire logic  sample_ready,
	input  wire in_t   sample,
	input  wire logic  result_valid,
	input  wire logic  result_ready,
	input  wire out_t  result,
	input  wire logic  psel,
	input  wire logic  penable,
	input  wire logic  pwrite,
	input  wire logic  [3:0] paddr,
	input  wire logic  [31:0] pwdata,
	input  wire logic  pready,
	output int         fail_count,
	output int         pending
);

	localparam longint unsigned Q30 = 64'd1 << 30;
	localparam longint unsigned HORNER_DIV [5] = '{110, 72, 42, 20, 6};

	logic [15:0]      coef_q, gain_q, floor_q, scale_q;
	longint unsigned  env_q [2];
	longint unsigned  env_sum_q;
	int unsigned      blk_cnt_q;
	out_t             expected_results [$];

	assign pending = expected_results.size();

	function automatic out_t predict_result(in_t s);
		out_t            o;
		longint unsigned raw, mag, env, den, ang, x2, t, y, mean, rad, root, bit_v, l;
		bit              neg;
		int              ch;
		raw  = 64'(unsigned'(s.sample_in));
		neg  = raw[23];
		mag  = neg ? (64'h100_0000 - raw) : raw;
		ch   = s.channel;
		env  = (env_q[ch] * (65536 - coef_q) + mag * coef_q + 32768) >> 16;
		env_q[ch] = env;
		den  = env + (64'(floor_q) << 7);
		if (den == 0)
			den = 1;
		ang = ((mag * gain_q) << 15) / den;
		if (ang > HALF_PI_Q30)
			ang = HALF_PI_Q30;
		x2 = (ang * ang) >> 30;
		t  = Q30;
		for (int i = 0; i < 5; i++)
			t = Q30 - ((x2 * t) >> 30) / HORNER_DIV[i];
		t = (ang * t) >> 30;
		if (t > Q30)
			t = Q30;
		y = (t * scale_q + (64'd1 << 22)) >> 23;
		if (y > 8388607)
			y = 8388607;
		o.sample_out = neg ? -24'(y) : 24'(y);
		if (blk_cnt_q < MAX_BLOCK) begin
			env_sum_q += env;
			blk_cnt_q++;
		end
		if (s.block_last) begin
			mean  = env_sum_q / (blk_cnt_q != 0 ? blk_cnt_q : 1);
			rad   = mean << 37;
			root  = 0;
			bit_v = 64'd1 << 62;
			while (bit_v > rad)
				bit_v >>= 2;
			while (bit_v != 0) begin
				if (rad >= root + bit_v) begin
					rad -= root + bit_v;
					root = (root >> 1) + bit_v;
				end else begin
					root >>= 1;
				end
				bit_v >>= 2;
			end
			l = (root * LOUD_GAIN_Q16 + Q30) >> 31;
			o.loudness       = l > 65535 ? 16'hFFFF : 16'(l);
			o.loudness_valid = 1'b1;
			env_sum_q = 0;
			blk_cnt_q = 0;
		end else begin
			o.loudness       = '0;
			o.loudness_valid = 1'b0;
		end
		return o;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("%0t: result %s got %0d expected %0d", $time, field, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t e;
		if (!arst_n) begin
			coef_q    <= SMOOTH_COEF_RST;
			gain_q    <= MASTER_GAIN_RST;
			floor_q   <= ENV_FLOOR_RST;
			scale_q   <= OUTPUT_SCALE_RST;
			env_q[0]  = 0;
			env_q[1]  = 0;
			env_sum_q = 0;
			blk_cnt_q = 0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SMOOTH_COEF:  coef_q  <= pwdata[15:0];
					REG_MASTER_GAIN:  gain_q  <= pwdata[15:0];
					REG_ENV_FLOOR:    floor_q <= pwdata[15:0];
					REG_OUTPUT_SCALE: scale_q <= pwdata[15:0];
				endcase
			end
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result transfer with nothing expected", $time);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (result.sample_out !== e.sample_out)
						report_mismatch("sample_out", result.sample_out, e.sample_out);
					if (result.loudness !== e.loudness)
						report_mismatch("loudness", result.loudness, e.loudness);
					if (result.loudness_valid !== e.loudness_valid)
						report_mismatch("loudness_valid", result.loudness_valid,
							e.loudness_valid);
				end
			end
			if (sample_valid && sample_ready)
				expected_results.push_back(predict_result(sample));
		end
	end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the compressor core: register settings through the APB port,
// directed extreme samples, then phases of random blocks under changing
// settings and flow control, with one long output stall. The checker
// beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import ecsc_pkg::*;

	localparam longint CYCLE_LIMIT = 8_000_000;
	localparam int     PHASES      = 6;
	localparam int     PHASE_ITEMS = 300;

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_ready;
	in_t         sample;
	logic        result_valid;
	logic        result_ready;
	out_t        result;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int     fail_count;
	int     pending;
	int     send_gap_pct;
	int     recv_stall_pct;
	bit     hold_req;
	longint cycles;

	envelope_compressor_soft_clip_core u_top (
		.clk, .arst_n, .sample_valid, .sample_ready, .sample,
		.result_valid, .result_ready, .result,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	ecsc_result_checker u_checker (
		.clk, .arst_n, .sample_valid, .sample_ready, .sample,
		.result_valid, .result_ready, .result,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.fail_count, .pending
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("envelope_compressor_soft_clip_core: mismatch");
				$finish;
			end
		end
	end

	// output side: random stalls, plus one long hold-off on request
	initial begin
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ready <= 1'b0;
				repeat (4000) @(posedge clk);
			end
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// back-to-back writes; the caller closes the bus
	task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	task automatic cfg_all(logic [15:0] c, logic [15:0] g, logic [15:0] f, logic [15:0] s);
		cfg_write(REG_SMOOTH_COEF, c);
		cfg_write(REG_MASTER_GAIN, g);
		cfg_write(REG_ENV_FLOOR, f);
		cfg_write(REG_OUTPUT_SCALE, s);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_sample(logic signed [23:0] v, logic ch, logic last);
		while ($urandom_range(99) < send_gap_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample.sample_in  <= v;
		sample.channel    <= ch;
		sample.block_last <= last;
		sample_valid      <= 1'b1;
		do @(posedge clk); while (!sample_ready);
	endtask

	task automatic wait_idle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_reg();
		case ($urandom_range(5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(255));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [23:0] rand_sample();
		int w;
		w = $urandom_range(24, 1);
		case ($urandom_range(9))
			0:       return 24'sh800000;
			1:       return 24'sh7FFFFF;
			2:       return 24'($urandom);
			default: return 24'($signed(32'($urandom) << (32 - w)) >>> (32 - w));
		endcase
	endfunction

	initial begin
		logic [15:0] fl;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		hold_req     = 1'b0;
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, extreme samples on both channels
		send_sample(24'sh7FFFFF, 1'b0, 1'b0);
		send_sample(24'sh800000, 1'b1, 1'b0);
		send_sample(24'sh000000, 1'b0, 1'b0);
		send_sample(-24'sd1, 1'b1, 1'b0);
		send_sample(24'sd1, 1'b0, 1'b1);
		send_sample(24'sd1, 1'b0, 1'b1);
		wait_idle();

		// fastest envelope, max gain, zero floor: zero divisor on silent channel
		cfg_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_sample(24'sh000000, 1'b0, 1'b0);
		send_sample(24'sh000000, 1'b0, 1'b0);
		send_sample(24'sd5, 1'b0, 1'b0);
		send_sample(24'sh800000, 1'b1, 1'b0);
		send_sample(24'sh7FFFFF, 1'b1, 1'b1);
		wait_idle();

		// frozen envelope, zero gain and scale, largest floor
		cfg_all(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
		send_sample(24'sh7FFFFF, 1'b0, 1'b0);
		send_sample(24'sh800000, 1'b1, 1'b1);
		wait_idle();

		// smallest floor, loud gain
		cfg_all(16'h8000, 16'hFFFF, 16'h0001, 16'hFFFF);
		send_sample(24'sh400000, 1'b0, 1'b0);
		send_sample(24'shC00000, 1'b1, 1'b0);
		send_sample(24'sh7FFFFF, 1'b0, 1'b0);
		send_sample(24'sh800000, 1'b1, 1'b0);
		send_sample(24'sh7FFFFF, 1'b0, 1'b1);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			if (p < 2) begin
				send_gap_pct = 12;
				recv_stall_pct = 81;
			end else if (p < 4) begin
				send_gap_pct = 81;
				recv_stall_pct = 12;
			end else begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			fl = rand_reg();
			if (fl == 0 && $urandom_range(1))
				fl = 16'd1;
			if (p == PHASES - 1)
				cfg_all(SMOOTH_COEF_RST, MASTER_GAIN_RST, ENV_FLOOR_RST, OUTPUT_SCALE_RST);
			else
				cfg_all(rand_reg(), rand_reg(), fl, rand_reg());
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == PHASES - 1 && i == 50)
					hold_req = 1'b1;
				send_sample(rand_sample(), 1'($urandom), $urandom_range(15) == 0);
			end
			wait_idle();
		end

		repeat (600) @(posedge clk);
		if (fail_count == 0)
			$display("envelope_compressor_soft_clip_core: match");
		else
			$display("envelope_compressor_soft_clip_core: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
